[src/sorted_priority_queue_unit_defines.svh]
// Assertion macros for the sorted priority queue unit.
// Used by sorted_priority_queue_unit.sv; the clock and reset names are fixed there.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge outside of reset.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
// Checked on every rising edge, reset included.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);
`else
`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[src/spq_pkg.sv]
// Shared types and constants of the sorted priority queue unit.
// No dependencies; used by the interfaces, the cell row, the result stage and the top level.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int KEY_W = 64;

    // Operation codes of the kind field.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Control sent from the top level to every storage cell.
    typedef struct packed {
        logic write;    // an operation that advances and is not refused changes the store this cycle
        logic pop;      // shift toward the head instead of inserting
    } t_cell_ctl;

endpackage

[src/spq_in_if.sv]
// Input channel of the sorted priority queue unit: one operation per transfer.
// Depends on spq_pkg for the key width.
`timescale 1ns / 1ps

interface spq_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [spq_pkg::KEY_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

[src/spq_out_if.sv]
// Result channel of the sorted priority queue unit: one status word per transfer.
// Depends on spq_pkg for the key width; CNT_W follows the store depth.
`timescale 1ns / 1ps

interface spq_out_if #(
    parameter int CNT_W = 5
);
    logic                      valid;
    logic                      ready;
    logic [spq_pkg::KEY_W-1:0] head_key;
    logic                      is_empty;
    logic [CNT_W-1:0]          entry_count;
    logic                      refused;

    modport source (output valid, output head_key, output is_empty, output entry_count,
                    output refused, input ready);
    modport sink   (input valid, input head_key, input is_empty, input entry_count,
                    input refused, output ready);
endinterface

[src/spq_cell.sv]
// One entry of the sorted store: key register, compare against the new key, next-value select.
// Depends on spq_pkg for the key width and the cell control struct.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctl        i_ctl,
    input  logic [spq_pkg::KEY_W-1:0] i_key,       // key being pushed
    input  logic                      i_occupied,  // entry lies below the stored count
    input  logic                      i_prev_le,   // neighbor toward the head stays put
    input  logic [spq_pkg::KEY_W-1:0] i_prev_key,
    input  logic [spq_pkg::KEY_W-1:0] i_next_key,
    output logic                      o_le,
    output logic [spq_pkg::KEY_W-1:0] o_key,
    output logic [spq_pkg::KEY_W-1:0] o_next_key
);

    logic [spq_pkg::KEY_W-1:0] r_key;
    logic [spq_pkg::KEY_W-1:0] n_key;

    // Stored keys are ascending, so the le flags form a thermometer code and equal
    // keys keep their place ahead of the new one.
    assign o_le = i_occupied && (r_key <= i_key);

    always_comb begin
        if (i_ctl.pop) begin
            n_key = i_next_key;
        end else if (o_le) begin
            n_key = r_key;
        end else if (i_prev_le) begin
            n_key = i_key;
        end else begin
            n_key = i_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.write) begin
            r_key <= n_key;
        end
    end

    assign o_key      = r_key;
    assign o_next_key = n_key;

endmodule

[src/spq_out_stage.sv]
// Result register of the sorted priority queue unit with its valid/ready control.
// Depends on spq_pkg and spq_out_if.
`timescale 1ns / 1ps

module spq_out_stage #(
    parameter int CNT_W = 5
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [spq_pkg::KEY_W-1:0] i_head_key,
    input  logic                      i_is_empty,
    input  logic [CNT_W-1:0]          i_entry_count,
    input  logic                      i_refused,
    output logic                      o_free,
    spq_out_if.source                 o_out
);

    logic                      r_valid;
    logic [spq_pkg::KEY_W-1:0] r_head_key;
    logic                      r_is_empty;
    logic [CNT_W-1:0]          r_entry_count;
    logic                      r_refused;

    // A new result may enter while the current one is being taken.
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_head_key    <= i_head_key;
            r_is_empty    <= i_is_empty;
            r_entry_count <= i_entry_count;
            r_refused     <= i_refused;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.head_key    = r_head_key;
    assign o_out.is_empty    = r_is_empty;
    assign o_out.entry_count = r_entry_count;
    assign o_out.refused     = r_refused;

endmodule

[src/sorted_priority_queue_unit.sv]
// Top level of the sorted priority queue unit: input register, row of storage cells, count.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_cell, spq_out_stage and the defines header.
//
//   Channel   Role    Transfer moves
//   i_in      sink    kind (push/pop), key
//   o_out     source  head_key, is_empty, entry_count, refused
//
// One operation is accepted per cycle while o_out is not stalled; its result passes from the
// input register into the result register and is then valid on o_out; a stall can hold it between.
// The rate is set by the cell row: every entry compares with the new key at once and
// takes its next value in the same cycle, so a following operation sees the updated store.
// Reset clears the stored count and the valid flags; key registers are not cleared.
// A stalled result holds the input register, and i_in.ready falls once both are full.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit #(
    parameter int DEPTH     = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    spq_in_if.sink  i_in,
    spq_out_if.source o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [spq_pkg::KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {spq_pkg::KEY_W{1'b1}} :
        ((spq_pkg::KEY_W'(1) << (8 * KEY_BYTES)) - spq_pkg::KEY_W'(1));
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Input register.
    logic                      r_in_valid;
    logic                      r_kind;
    logic [spq_pkg::KEY_W-1:0] r_key;

    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;

    logic                      out_free;
    logic                      advance;
    logic                      refuse;
    spq_pkg::t_cell_ctl        cell_ctl;

    logic [DEPTH-1:0]          le;
    logic [spq_pkg::KEY_W-1:0] cell_key      [DEPTH];
    logic [spq_pkg::KEY_W-1:0] cell_next_key [DEPTH];

    logic [spq_pkg::KEY_W-1:0] head_key;

    assign advance    = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_kind <= i_in.kind;
            r_key  <= i_in.key & KEY_MASK;
        end
    end

    always_comb begin
        case (r_kind)
            spq_pkg::OP_PUSH: begin
                refuse  = (r_count == FULL_COUNT);
                n_count = r_count + CNT_W'(1);
            end
            spq_pkg::OP_POP: begin
                refuse  = (r_count == '0);
                n_count = r_count - CNT_W'(1);
            end
            default: begin
                refuse  = 1'b1;
                n_count = r_count;
            end
        endcase
    end

    assign cell_ctl.write = advance && !refuse;
    assign cell_ctl.pop   = (r_kind == spq_pkg::OP_POP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cell_ctl.write) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                      prev_le;
        logic [spq_pkg::KEY_W-1:0] prev_key;
        logic [spq_pkg::KEY_W-1:0] next_key;

        if (g == 0) begin : g_head
            assign prev_le  = 1'b1;
            assign prev_key = r_key;
        end else begin : g_body
            assign prev_le  = le[g-1];
            assign prev_key = cell_key[g-1];
        end

        // The last entry has no successor; its value past the count is never read.
        if (g == DEPTH - 1) begin : g_tail
            assign next_key = cell_key[g];
        end else begin : g_inner
            assign next_key = cell_key[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (cell_ctl),
            .i_key      (r_key),
            .i_occupied (r_count > CNT_W'(g)),
            .i_prev_le  (prev_le),
            .i_prev_key (prev_key),
            .i_next_key (next_key),
            .o_le       (le[g]),
            .o_key      (cell_key[g]),
            .o_next_key (cell_next_key[g])
        );
    end

    // Status after the operation: a refused one leaves the store as it was.
    logic [CNT_W-1:0] res_count;
    assign res_count = refuse ? r_count : n_count;
    assign head_key  = (res_count == '0) ? '0 :
                       (refuse ? cell_key[0] : cell_next_key[0]);

    spq_out_stage #(
        .CNT_W (CNT_W)
    ) u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance),
        .i_head_key    (head_key),
        .i_is_empty    (res_count == '0),
        .i_entry_count (res_count),
        .i_refused     (refuse),
        .o_free        (out_free),
        .o_out         (o_out)
    );

    `SPQ_ASSERT_ALWAYS(a_count_bound, !i_rst_n || (r_count <= FULL_COUNT),
        "stored count exceeds depth")
    `SPQ_ASSERT(a_refused_holds, advance && refuse |=> $stable(r_count),
        "refused operation changed the stored count")
    `SPQ_ASSERT(a_empty_flag, o_out.valid |-> (o_out.is_empty == (o_out.entry_count == '0)),
        "empty flag disagrees with entry count")
    `SPQ_ASSERT(a_head_order, r_count >= CNT_W'(2) |-> cell_key[0] <= cell_key[1],
        "head entry is larger than its successor")

endmodule
